/* design/tlp_pkg.sv */
`default_nettype none
package tlp_pkg;

  localparam int LBL_W   = 2;
  localparam int FWD_W   = 6;
  localparam int SPLIT_W = 7;

  localparam logic [LBL_W-1:0] LABEL_FIRST = 2'd0;
  localparam logic [LBL_W-1:0] LABEL_SEP   = 2'd2;

  // controller -> datapath
  typedef struct packed {
    logic load;        // input request taken
    logic pass_init;   // start first pass over [0, count)
    logic pass2_init;  // capture first split, start second pass there
    logic pass_done;   // capture second split, reset emit index
    logic rd_lo;       // read label at lo
    logic rd_hi;       // read label at hi
    logic lo_inc;
    logic hi_dec;
    logic swap_rd;     // read labels/forwards at lo and hi
    logic swap_wr1;    // write lo side, read inverses
    logic swap_wr2;    // write hi side, first inverse
    logic swap_wr3;    // second inverse
    logic emit_rd;     // read element k
    logic emit_load;   // move element k to output register
    logic clear_count;
  } cmd_t;

  // datapath -> controller
  typedef struct packed {
    logic lo_lt_hi;
    logic lo_eq_hi;
    logic moves;       // label read at port A belongs behind the split
    logic second;
    logic emit_last;
    logic out_free;
  } sts_t;

endpackage
`default_nettype wire

/* design/tlp_ctrl.sv */
`default_nettype none
module tlp_ctrl (
  input  wire logic          clk,
  input  wire logic          rst_n,
  input  wire logic          in_valid,
  input  wire logic          in_last_element,
  output logic               in_stall,
  output tlp_pkg::cmd_t      cmd,
  input  wire tlp_pkg::sts_t sts
);
  import tlp_pkg::*;

  typedef enum logic [3:0] {
    S_LOAD, S_INIT, S_CHK, S_RDLO, S_SCAN, S_SCANW,
    S_SWAP, S_WR1, S_WR2, S_WR3, S_EMRD, S_EMLD
  } state_t;

  state_t state_r, state_nxt;

  always_comb begin
    state_nxt = state_r;
    cmd       = '0;
    case (state_r)
      S_LOAD: begin
        cmd.load = in_valid;
        if (in_valid && in_last_element) state_nxt = S_INIT;
      end
      S_INIT: begin
        cmd.pass_init = 1'b1;
        state_nxt     = S_CHK;
      end
      S_CHK: begin
        if (sts.lo_lt_hi) begin
          cmd.rd_lo = 1'b1;
          state_nxt = S_RDLO;
        end else if (sts.second) begin
          cmd.pass_done = 1'b1;
          state_nxt     = S_EMRD;
        end else begin
          cmd.pass2_init = 1'b1;
        end
      end
      S_RDLO: begin
        if (sts.moves) begin
          cmd.hi_dec = 1'b1;
          state_nxt  = S_SCAN;
        end else begin
          cmd.lo_inc = 1'b1;
          state_nxt  = S_CHK;
        end
      end
      S_SCAN: begin
        if (sts.lo_lt_hi) begin
          cmd.rd_hi = 1'b1;
          state_nxt = S_SCANW;
        end else begin
          state_nxt = S_SWAP;
        end
      end
      S_SCANW: begin
        if (sts.moves) begin
          cmd.hi_dec = 1'b1;
          state_nxt  = S_SCAN;
        end else begin
          state_nxt = S_SWAP;
        end
      end
      S_SWAP: begin
        // swapping a slot with itself changes nothing
        if (sts.lo_eq_hi) begin
          cmd.lo_inc = 1'b1;
          state_nxt  = S_CHK;
        end else begin
          cmd.swap_rd = 1'b1;
          state_nxt   = S_WR1;
        end
      end
      S_WR1: begin
        cmd.swap_wr1 = 1'b1;
        state_nxt    = S_WR2;
      end
      S_WR2: begin
        cmd.swap_wr2 = 1'b1;
        state_nxt    = S_WR3;
      end
      S_WR3: begin
        cmd.swap_wr3 = 1'b1;
        cmd.lo_inc   = 1'b1;
        state_nxt    = S_CHK;
      end
      S_EMRD: begin
        cmd.emit_rd = 1'b1;
        state_nxt   = S_EMLD;
      end
      S_EMLD: begin
        if (sts.out_free) begin
          cmd.emit_load = 1'b1;
          if (sts.emit_last) begin
            cmd.clear_count = 1'b1;
            state_nxt       = S_LOAD;
          end else begin
            state_nxt = S_EMRD;
          end
        end
      end
      default: state_nxt = S_LOAD;
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= S_LOAD;
    end else begin
      state_r <= state_nxt;
    end
  end

  assign in_stall = (state_r != S_LOAD);

endmodule
`default_nettype wire

/* design/tlp_dp.sv */
`default_nettype none
module tlp_dp #(
  parameter int MAX_ELEMENTS = 64
) (
  input  wire logic                          clk,
  input  wire logic                          rst_n,
  input  wire tlp_pkg::cmd_t                 cmd,
  output tlp_pkg::sts_t                      sts,
  input  wire logic [tlp_pkg::LBL_W-1:0]     in_part_label,
  input  wire logic [tlp_pkg::FWD_W-1:0]     in_forward_entry,
  input  wire logic [tlp_pkg::FWD_W-1:0]     in_inverse_entry,
  output logic                               out_valid,
  input  wire logic                          out_stall,
  output logic [tlp_pkg::LBL_W-1:0]          out_label,
  output logic [tlp_pkg::FWD_W-1:0]          out_forward,
  output logic [tlp_pkg::FWD_W-1:0]          out_inverse,
  output logic [tlp_pkg::SPLIT_W-1:0]        out_first_split,
  output logic [tlp_pkg::SPLIT_W-1:0]        out_second_split,
  output logic                               out_last_result
);
  import tlp_pkg::*;

  localparam int AW   = $clog2(MAX_ELEMENTS);
  localparam int CW   = $clog2(MAX_ELEMENTS + 1);
  localparam int CMPW = (CW > FWD_W) ? CW : FWD_W;

  logic [LBL_W-1:0] lbl_mem [MAX_ELEMENTS];
  logic [FWD_W-1:0] fwd_mem [MAX_ELEMENTS];
  logic [FWD_W-1:0] inv_mem [MAX_ELEMENTS];

  logic [CW-1:0]    cnt_r, lo_r, hi_r, s0_r, s1_r;
  logic [AW-1:0]    k_r;
  logic             second_r;
  logic [LBL_W-1:0] lbl_rd_a_r, lbl_rd_b_r;
  logic [FWD_W-1:0] fwd_rd_a_r, fwd_rd_b_r;
  logic [FWD_W-1:0] inv_rd_a_r, inv_rd_b_r;

  logic [LBL_W-1:0]   out_label_r;
  logic [FWD_W-1:0]   out_forward_r, out_inverse_r;
  logic [SPLIT_W-1:0] out_first_split_r, out_second_split_r;
  logic               out_last_result_r, out_valid_r;

  logic [CW-1:0] split;
  logic          load_wr, fwd_ok, out_taken, emit_last;
  logic [AW-1:0] lo_idx, hi_idx, cnt_idx;

  assign lo_idx  = lo_r[AW-1:0];
  assign hi_idx  = hi_r[AW-1:0];
  assign cnt_idx = cnt_r[AW-1:0];

  assign load_wr   = cmd.load && (cnt_r < CW'(MAX_ELEMENTS));
  assign split     = (lo_r > hi_r) ? (lo_r - CW'(1)) : hi_r;
  // inverse entries move only when both forward values address stored slots
  assign fwd_ok    = (CMPW'(fwd_rd_a_r) < CMPW'(cnt_r)) && (CMPW'(fwd_rd_b_r) < CMPW'(cnt_r));
  assign out_taken = out_valid_r && !out_stall;
  assign emit_last = ((CW'(k_r) + CW'(1)) == cnt_r);

  always_comb begin
    sts.lo_lt_hi  = (lo_r < hi_r);
    sts.lo_eq_hi  = (lo_r == hi_r);
    sts.moves     = second_r ? (lbl_rd_a_r == LABEL_SEP) : (lbl_rd_a_r != LABEL_FIRST);
    sts.second    = second_r;
    sts.emit_last = emit_last;
    sts.out_free  = !out_valid_r || !out_stall;
  end

  // label store: one write port, two read ports
  always_ff @(posedge clk) begin
    if (load_wr) begin
      lbl_mem[cnt_idx] <= in_part_label;
    end else if (cmd.swap_wr1) begin
      lbl_mem[lo_idx] <= lbl_rd_b_r;
    end else if (cmd.swap_wr2) begin
      lbl_mem[hi_idx] <= lbl_rd_a_r;
    end
    if (cmd.rd_lo || cmd.rd_hi || cmd.swap_rd || cmd.emit_rd) begin
      lbl_rd_a_r <= lbl_mem[cmd.rd_hi ? hi_idx : (cmd.emit_rd ? k_r : lo_idx)];
      lbl_rd_b_r <= lbl_mem[hi_idx];
    end
  end

  // forward store
  always_ff @(posedge clk) begin
    if (load_wr) begin
      fwd_mem[cnt_idx] <= in_forward_entry;
    end else if (cmd.swap_wr1) begin
      fwd_mem[lo_idx] <= fwd_rd_b_r;
    end else if (cmd.swap_wr2) begin
      fwd_mem[hi_idx] <= fwd_rd_a_r;
    end
    if (cmd.swap_rd || cmd.emit_rd) begin
      fwd_rd_a_r <= fwd_mem[cmd.emit_rd ? k_r : lo_idx];
      fwd_rd_b_r <= fwd_mem[hi_idx];
    end
  end

  // inverse store, addressed by the old forward values during a swap
  always_ff @(posedge clk) begin
    if (load_wr) begin
      inv_mem[cnt_idx] <= in_inverse_entry;
    end else if (cmd.swap_wr2 && fwd_ok) begin
      inv_mem[AW'(fwd_rd_a_r)] <= inv_rd_b_r;
    end else if (cmd.swap_wr3 && fwd_ok) begin
      inv_mem[AW'(fwd_rd_b_r)] <= inv_rd_a_r;
    end
    if (cmd.swap_wr1 || cmd.emit_rd) begin
      inv_rd_a_r <= inv_mem[cmd.emit_rd ? k_r : AW'(fwd_rd_a_r)];
      inv_rd_b_r <= inv_mem[AW'(fwd_rd_b_r)];
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      cnt_r       <= '0;
      lo_r        <= '0;
      hi_r        <= '0;
      k_r         <= '0;
      second_r    <= 1'b0;
      s0_r        <= '0;
      s1_r        <= '0;
      out_valid_r <= 1'b0;
    end else begin
      if (cmd.clear_count) begin
        cnt_r <= '0;
      end else if (load_wr) begin
        cnt_r <= cnt_r + CW'(1);
      end

      if (cmd.pass_init) begin
        lo_r     <= '0;
        hi_r     <= cnt_r;
        second_r <= 1'b0;
      end else if (cmd.pass2_init) begin
        s0_r     <= split;
        lo_r     <= split;
        hi_r     <= cnt_r;
        second_r <= 1'b1;
      end else begin
        if (cmd.lo_inc) lo_r <= lo_r + CW'(1);
        if (cmd.hi_dec) hi_r <= hi_r - CW'(1);
      end

      if (cmd.pass_done) begin
        s1_r <= split;
        k_r  <= '0;
      end else if (cmd.emit_load) begin
        k_r <= k_r + AW'(1);
      end

      if (cmd.emit_load) begin
        out_valid_r <= 1'b1;
      end else if (out_taken) begin
        out_valid_r <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.emit_load) begin
      out_label_r        <= lbl_rd_a_r;
      out_forward_r      <= fwd_rd_a_r;
      out_inverse_r      <= inv_rd_a_r;
      out_first_split_r  <= SPLIT_W'(s0_r);
      out_second_split_r <= SPLIT_W'(s1_r);
      out_last_result_r  <= emit_last;
    end
  end

  assign out_valid        = out_valid_r;
  assign out_label        = out_label_r;
  assign out_forward      = out_forward_r;
  assign out_inverse      = out_inverse_r;
  assign out_first_split  = out_first_split_r;
  assign out_second_split = out_second_split_r;
  assign out_last_result  = out_last_result_r;

endmodule
`default_nettype wire

/* design/three_way_label_partition_top.sv */
// Channel   Handshake            Payload
// in_       in_valid / in_stall  part_label, forward_entry, inverse_entry, last_element
// out_      out_valid / out_stall label, forward, inverse, first/second split, last_result
//
// Loading takes one request per cycle; the request with last_element closes the list.
// Each partition pass reads each scanned slot from a registered store, exchanges two slots
// in S_SWAP, S_WR1, S_WR2 and S_WR3 (one write port per store), skips a self-exchange and
// closes in S_CHK; each element is emitted via S_EMRD and S_EMLD, waiting on out_stall.
// in_stall is high from the last request until the final element sits in the
// output register. rst_n is synchronous; store contents are not cleared.
`default_nettype none
module three_way_label_partition_top #(
  parameter int MAX_ELEMENTS = 64
) (
  input  wire logic                          clk,
  input  wire logic                          rst_n,
  input  wire logic                          in_valid,
  output logic                               in_stall,
  input  wire logic [tlp_pkg::LBL_W-1:0]     in_part_label,
  input  wire logic [tlp_pkg::FWD_W-1:0]     in_forward_entry,
  input  wire logic [tlp_pkg::FWD_W-1:0]     in_inverse_entry,
  input  wire logic                          in_last_element,
  output logic                               out_valid,
  input  wire logic                          out_stall,
  output logic [tlp_pkg::LBL_W-1:0]          out_label,
  output logic [tlp_pkg::FWD_W-1:0]          out_forward,
  output logic [tlp_pkg::FWD_W-1:0]          out_inverse,
  output logic [tlp_pkg::SPLIT_W-1:0]        out_first_split,
  output logic [tlp_pkg::SPLIT_W-1:0]        out_second_split,
  output logic                               out_last_result
);
  import tlp_pkg::*;

  cmd_t cmd;
  sts_t sts;

  tlp_ctrl u_ctrl (
    .clk             (clk),
    .rst_n           (rst_n),
    .in_valid        (in_valid),
    .in_last_element (in_last_element),
    .in_stall        (in_stall),
    .cmd             (cmd),
    .sts             (sts)
  );

  tlp_dp #(
    .MAX_ELEMENTS (MAX_ELEMENTS)
  ) u_dp (
    .clk              (clk),
    .rst_n            (rst_n),
    .cmd              (cmd),
    .sts              (sts),
    .in_part_label    (in_part_label),
    .in_forward_entry (in_forward_entry),
    .in_inverse_entry (in_inverse_entry),
    .out_valid        (out_valid),
    .out_stall        (out_stall),
    .out_label        (out_label),
    .out_forward      (out_forward),
    .out_inverse      (out_inverse),
    .out_first_split  (out_first_split),
    .out_second_split (out_second_split),
    .out_last_result  (out_last_result)
  );

endmodule
`default_nettype wire

/* dv/label_partition_check.sv */
`default_nettype none
module label_partition_check #(
  parameter int MAX_ELEMENTS = 64
) (
  input  wire logic                        clk,
  input  wire logic                        rst_n,
  input  wire logic                        in_valid,
  input  wire logic                        in_stall,
  input  wire logic [tlp_pkg::LBL_W-1:0]   in_part_label,
  input  wire logic [tlp_pkg::FWD_W-1:0]   in_forward_entry,
  input  wire logic [tlp_pkg::FWD_W-1:0]   in_inverse_entry,
  input  wire logic                        in_last_element,
  input  wire logic                        out_valid,
  input  wire logic                        out_stall,
  input  wire logic [tlp_pkg::LBL_W-1:0]   out_label,
  input  wire logic [tlp_pkg::FWD_W-1:0]   out_forward,
  input  wire logic [tlp_pkg::FWD_W-1:0]   out_inverse,
  input  wire logic [tlp_pkg::SPLIT_W-1:0] out_first_split,
  input  wire logic [tlp_pkg::SPLIT_W-1:0] out_second_split,
  input  wire logic                        out_last_result,
  output int                               mismatches,
  output int                               outstanding,
  output int                               results_checked,
  output int                               lists_closed
);
  timeunit 1ns;
  timeprecision 1ps;
  import tlp_pkg::*;

  typedef struct packed {
    logic [LBL_W-1:0]   label;
    logic [FWD_W-1:0]   fwd;
    logic [FWD_W-1:0]   inv;
    logic [SPLIT_W-1:0] split0;
    logic [SPLIT_W-1:0] split1;
    logic               is_last;
  } elem_t;

  elem_t expected_elems[$];

  logic [LBL_W-1:0] labels[MAX_ELEMENTS];
  logic [FWD_W-1:0] fwds[MAX_ELEMENTS];
  logic [FWD_W-1:0] invs[MAX_ELEMENTS];
  int held;

  initial begin
    mismatches      = 0;
    outstanding     = 0;
    results_checked = 0;
    lists_closed    = 0;
    held            = 0;
  end

  // Exchange two positions; inverses move only when both forward values index stored slots.
  function automatic void swap_pair(int a, int b, int n);
    logic [FWD_W-1:0] t;
    logic [LBL_W-1:0] tl;
    int fa, fb;
    if (a >= n || b >= n) return;
    t = fwds[a];
    fwds[a] = fwds[b];
    fwds[b] = t;
    fa = fwds[a];
    fb = fwds[b];
    if (fa < n && fb < n) begin
      t = invs[fa];
      invs[fa] = invs[fb];
      invs[fb] = t;
    end
    tl = labels[a];
    labels[a] = labels[b];
    labels[b] = tl;
  endfunction

  // Label three is nonzero for the first pass but not a separator in the second.
  function automatic bit goes_back(logic [LBL_W-1:0] l, bit second);
    return second ? (l == LABEL_SEP) : (l != LABEL_FIRST);
  endfunction

  function automatic int sweep(int start, int n, bit second);
    int lo, hi;
    lo = start;
    hi = n;
    while (lo < hi) begin
      if (goes_back(labels[lo], second)) begin
        hi--;
        while (lo < hi && goes_back(labels[hi], second)) hi--;
        swap_pair(lo, hi, n);
      end
      lo++;
    end
    return (lo > hi) ? lo - 1 : hi;
  endfunction

  function automatic void partition_list();
    int s0, s1;
    elem_t e;
    s0 = sweep(0, held, 1'b0);
    s1 = sweep(s0, held, 1'b1);
    for (int k = 0; k < held; k++) begin
      e.label   = labels[k];
      e.fwd     = fwds[k];
      e.inv     = invs[k];
      e.split0  = SPLIT_W'(s0);
      e.split1  = SPLIT_W'(s1);
      e.is_last = (k + 1 == held);
      expected_elems.push_back(e);
    end
    held = 0;
    lists_closed++;
  endfunction

  always @(posedge clk) begin
    elem_t want;
    if (!rst_n) begin
      held = 0;
      expected_elems.delete();
    end else begin
      if (in_valid && !in_stall) begin
        // a full store drops the request but still honors its last flag
        if (held < MAX_ELEMENTS) begin
          labels[held] = in_part_label;
          fwds[held]   = in_forward_entry;
          invs[held]   = in_inverse_entry;
          held++;
        end
        if (in_last_element) partition_list();
      end
      if (out_valid && !out_stall) begin
        if (expected_elems.size() == 0) begin
          mismatches++;
          if (mismatches <= 10)
            $display("%0t: unexpected result label=%0d fwd=%0d inv=%0d split=%0d/%0d last=%0b",
                     $realtime, out_label, out_forward, out_inverse, out_first_split,
                     out_second_split, out_last_result);
        end else begin
          want = expected_elems.pop_front();
          results_checked++;
          if (want.label !== out_label || want.fwd !== out_forward ||
              want.inv !== out_inverse || want.split0 !== out_first_split ||
              want.split1 !== out_second_split || want.is_last !== out_last_result) begin
            mismatches++;
            if (mismatches <= 10) begin
              $display("%0t: mismatch exp label=%0d fwd=%0d inv=%0d split=%0d/%0d last=%0b",
                       $realtime, want.label, want.fwd, want.inv, want.split0,
                       want.split1, want.is_last);
              $display("%0t:          got label=%0d fwd=%0d inv=%0d split=%0d/%0d last=%0b",
                       $realtime, out_label, out_forward, out_inverse, out_first_split,
                       out_second_split, out_last_result);
            end
          end
        end
      end
    end
    outstanding = expected_elems.size();
  end

endmodule
`default_nettype wire

/* dv/testbench.sv */
`default_nettype none
module testbench;
  timeunit 1ns;
  timeprecision 1ps;
  import tlp_pkg::*;

  localparam int MAX_ELEMENTS = 64;
  localparam int CYCLE_LIMIT  = 300000;
  localparam int RANDOM_ITEMS = 190;
  localparam logic [LBL_W-1:0] LABEL_SECOND = 2'd1;
  localparam logic [LBL_W-1:0] LABEL_ODD    = 2'd3;

  logic clk = 1'b0;
  logic rst_n = 1'b0;
  logic in_valid = 1'b0;
  logic in_stall;
  logic [LBL_W-1:0] in_part_label = '0;
  logic [FWD_W-1:0] in_forward_entry = '0;
  logic [FWD_W-1:0] in_inverse_entry = '0;
  logic in_last_element = 1'b0;
  logic out_valid;
  logic out_stall = 1'b0;
  logic [LBL_W-1:0] out_label;
  logic [FWD_W-1:0] out_forward;
  logic [FWD_W-1:0] out_inverse;
  logic [SPLIT_W-1:0] out_first_split;
  logic [SPLIT_W-1:0] out_second_split;
  logic out_last_result;

  int mismatches, outstanding, results_checked, lists_closed;
  int cycle_count = 0;
  logic calm = 1'b0;
  int perm[MAX_ELEMENTS];
  int perm_inv[MAX_ELEMENTS];

  three_way_label_partition_top #(.MAX_ELEMENTS(MAX_ELEMENTS)) dut (.*);

  label_partition_check #(.MAX_ELEMENTS(MAX_ELEMENTS)) check (.*);

  always begin
    clk = 1'b0;
    #2;
    clk = 1'b1;
    #2;
  end

  always @(posedge clk) begin
    out_stall <= !calm && ($urandom_range(0, 99) < 34);
  end

  always @(posedge clk) begin
    cycle_count <= cycle_count + 1;
    if (cycle_count >= CYCLE_LIMIT) begin
      $display("FAILURE");
      $finish;
    end
  end

  task automatic send_element(input logic [LBL_W-1:0] l, input logic [FWD_W-1:0] f,
                              input logic [FWD_W-1:0] v, input logic e);
    while (!calm && $urandom_range(0, 99) < 34) begin
      in_valid <= 1'b0;
      @(posedge clk);
    end
    in_valid         <= 1'b1;
    in_part_label    <= l;
    in_forward_entry <= f;
    in_inverse_entry <= v;
    in_last_element  <= e;
    @(posedge clk);
    while (in_stall) @(posedge clk);
  endtask

  task automatic build_perm(int n);
    int j, t;
    for (int i = 0; i < n; i++) perm[i] = i;
    for (int i = n - 1; i > 0; i--) begin
      j = $urandom_range(0, i);
      t = perm[i];
      perm[i] = perm[j];
      perm[j] = t;
    end
    for (int i = 0; i < n; i++) perm_inv[perm[i]] = i;
  endtask

  // shaped lists carry a true permutation and its inverse; the rest is noise
  task automatic send_list(int size, bit shaped);
    int stored;
    logic [LBL_W-1:0] l;
    logic [FWD_W-1:0] f, v;
    stored = (size > MAX_ELEMENTS) ? MAX_ELEMENTS : size;
    if (shaped) build_perm(stored);
    for (int i = 0; i < size; i++) begin
      l = ($urandom_range(0, 99) < 8) ? LABEL_ODD : LBL_W'($urandom_range(0, 2));
      if (shaped && i < stored) begin
        f = FWD_W'(perm[i]);
        v = FWD_W'(perm_inv[i]);
      end else begin
        f = FWD_W'($urandom_range(0, 63));
        v = FWD_W'($urandom_range(0, 63));
      end
      send_element(l, f, v, i == size - 1);
    end
  endtask

  initial begin
    int random_sent, size, r;
    bit full_done;
    random_sent = 0;
    full_done   = 1'b0;
    repeat (7) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);

    // single-element lists at both extremes
    send_element(LABEL_FIRST, 6'd0, 6'd0, 1'b1);
    send_element(LABEL_SEP, 6'd63, 6'd63, 1'b1);
    // reversed labels with a reversing permutation, label three at the front
    send_element(LABEL_ODD, 6'd3, 6'd3, 1'b0);
    send_element(LABEL_SEP, 6'd2, 6'd2, 1'b0);
    send_element(LABEL_SECOND, 6'd1, 6'd1, 1'b0);
    send_element(LABEL_FIRST, 6'd0, 6'd0, 1'b1);
    // forward values outside the list leave inverses alone
    send_element(LABEL_SEP, 6'd63, 6'd0, 1'b0);
    send_element(LABEL_SEP, 6'd0, 6'd63, 1'b0);
    send_element(LABEL_SECOND, 6'd40, 6'd21, 1'b0);
    send_element(LABEL_FIRST, 6'd1, 6'd42, 1'b0);
    send_element(LABEL_SECOND, 6'd2, 6'd63, 1'b1);
    // no label-0 or separator elements at all
    send_element(LABEL_SECOND, 6'd2, 6'd1, 1'b0);
    send_element(LABEL_SECOND, 6'd0, 6'd2, 1'b0);
    send_element(LABEL_SECOND, 6'd1, 6'd0, 1'b1);
    // mix with label three between separators
    send_element(LABEL_SEP, 6'd5, 6'd4, 1'b0);
    send_element(LABEL_ODD, 6'd4, 6'd5, 1'b0);
    send_element(LABEL_FIRST, 6'd3, 6'd3, 1'b0);
    send_element(LABEL_SEP, 6'd2, 6'd2, 1'b0);
    send_element(LABEL_FIRST, 6'd1, 6'd1, 1'b0);
    send_element(LABEL_SECOND, 6'd0, 6'd0, 1'b1);

    while (random_sent < RANDOM_ITEMS) begin
      calm <= (random_sent >= 110 && random_sent < 160);
      if (!full_done && random_sent >= 60) begin
        // overflow the store; the request with last is among the dropped ones
        full_done = 1'b1;
        size = MAX_ELEMENTS + 3;
        send_list(size, 1'b1);
      end else begin
        r = $urandom_range(0, 99);
        size = (r < 12) ? $urandom_range(11, 20) : $urandom_range(1, 10);
        send_list(size, $urandom_range(0, 99) < 80);
      end
      random_sent += size;
    end
    in_valid <= 1'b0;
    calm     <= 1'b0;

    @(negedge clk);
    while (outstanding != 0) @(negedge clk);
    repeat (20) @(posedge clk);

    $display("Covered %0d lists and checked %0d partitioned elements,", lists_closed,
             results_checked);
    $display("including label three, stray forward values and an overflowing list.");
    if (mismatches == 0) begin
      $display("SUCCESS");
    end else begin
      $display("FAILURE");
    end
    $finish;
  end

endmodule
`default_nettype wire
